// ----- rtl/rd_pkg.sv -----
// Package for the record deframer: widths, header positions, register map
// and the result word type. No dependencies.
package rd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int IDX_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Header byte positions; the body phase follows the last length byte.
    localparam logic [IDX_W-1:0] HDR_LEN_HIGH_POS = 3'd3;
    localparam logic [IDX_W-1:0] HDR_LEN_LOW_POS  = 3'd4;
    localparam logic [IDX_W-1:0] BODY_PHASE       = 3'd5;
    localparam logic [IDX_W-1:0] HDR_FIRST_POS    = 3'd0;

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 16'd16384;

    // Register index decoded from the word address bit.
    localparam logic REG_MAX_BODY_LENGTH = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_frame;
        logic              last_of_frame;
        logic              empty_frame;
        logic [LEN_W-1:0]  frame_length;
        logic              protocol_error;
    } t_result;

endpackage

// ----- rtl/rd_cfg.sv -----
// Configuration register block: APB-style write/read of max_body_length.
// Depends on rd_pkg.
module rd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                            pready,
    output logic [rd_pkg::LEN_W-1:0]        o_max_body_length
);
    import rd_pkg::*;

    logic [LEN_W-1:0] r_max_len;
    logic             w_sel_max;
    logic             w_wr;

    assign w_sel_max = (paddr[2] == REG_MAX_BODY_LENGTH);
    assign w_wr      = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_BODY_RESET;
        end else if (w_wr && w_sel_max) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, r_max_len};
        end
    end

    assign pready            = 1'b1;
    assign o_max_body_length = r_max_len;

endmodule

// ----- rtl/rd_parse.sv -----
// Header parser and body counter: consumes one accepted wire byte per cycle
// and produces at most one result word. Depends on rd_pkg.
module rd_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [rd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic [rd_pkg::LEN_W-1:0]    i_max_body_length,
    output logic                        o_res_push,
    output rd_pkg::t_result             o_res
);
    import rd_pkg::*;

    logic [IDX_W-1:0]  r_hdr_idx,  n_hdr_idx;
    logic [BYTE_W-1:0] r_len_high, n_len_high;
    logic [LEN_W-1:0]  r_body_len, n_body_len;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic              r_broken,   n_broken;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_rem_dec;

    assign w_len     = {r_len_high, i_rx_byte};
    assign w_rem_dec = (r_remaining != '0) ? LEN_W'(r_remaining - 16'd1) : r_remaining;

    always_comb begin
        n_hdr_idx   = r_hdr_idx;
        n_len_high  = r_len_high;
        n_body_len  = r_body_len;
        n_remaining = r_remaining;
        n_broken    = r_broken;
        o_res_push  = 1'b0;
        o_res       = '0;
        if (i_take && !r_broken) begin
            if (r_hdr_idx < HDR_LEN_HIGH_POS) begin
                n_hdr_idx = IDX_W'(r_hdr_idx + 3'd1);
            end else if (r_hdr_idx == HDR_LEN_HIGH_POS) begin
                n_len_high = i_rx_byte;
                n_hdr_idx  = HDR_LEN_LOW_POS;
            end else if (r_hdr_idx == HDR_LEN_LOW_POS) begin
                n_body_len = w_len;
                o_res.frame_length = w_len;
                if (w_len > i_max_body_length) begin
                    n_broken             = 1'b1;
                    n_hdr_idx            = HDR_FIRST_POS;
                    n_remaining          = '0;
                    o_res_push           = 1'b1;
                    o_res.protocol_error = 1'b1;
                end else if (w_len == '0) begin
                    n_hdr_idx            = HDR_FIRST_POS;
                    n_remaining          = '0;
                    o_res_push           = 1'b1;
                    o_res.first_of_frame = 1'b1;
                    o_res.last_of_frame  = 1'b1;
                    o_res.empty_frame    = 1'b1;
                end else begin
                    n_remaining = w_len;
                    n_hdr_idx   = BODY_PHASE;
                end
            end else begin
                n_remaining          = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_hdr_idx = HDR_FIRST_POS;
                end
                o_res_push           = 1'b1;
                o_res.payload_byte   = i_rx_byte;
                o_res.first_of_frame = (r_remaining == r_body_len);
                o_res.last_of_frame  = (r_remaining <= 16'd1);
                o_res.frame_length   = r_body_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx   <= HDR_FIRST_POS;
            r_len_high  <= '0;
            r_body_len  <= '0;
            r_remaining <= '0;
            r_broken    <= 1'b0;
        end else begin
            r_hdr_idx   <= n_hdr_idx;
            r_len_high  <= n_len_high;
            r_body_len  <= n_body_len;
            r_remaining <= n_remaining;
            r_broken    <= n_broken;
        end
    end

`ifndef SYNTH
    a_broken_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_broken |=> r_broken)
        else $error("stream error flag cleared without reset");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_idx <= BODY_PHASE)
        else $error("header index beyond body phase");
    a_rem_outside_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_idx != BODY_PHASE) |-> (r_remaining == '0))
        else $error("bytes remaining outside body phase");
    a_rem_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_idx == BODY_PHASE) |-> (r_remaining != '0 && r_remaining <= r_body_len))
        else $error("body counter out of range");
`endif

endmodule

// ----- rtl/rd_outbuf.sv -----
// Result register with a skid stage so the input side keeps flowing while
// the receiver stalls, until both hold a word. Depends on rd_pkg.
module rd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rd_pkg::t_result  i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output rd_pkg::t_result  o_res
);
    import rd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into full buffer");
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word not moved on pop");
`endif

endmodule

// ----- rtl/record_deframer.sv -----
// Record deframer top level: splits a wire byte stream into record bodies.
// Depends on rd_pkg, rd_cfg, rd_parse and rd_outbuf.
// Input channel: one wire byte per word on i_rx_byte, taken at a clock edge
// with i_rx_valid high and o_rx_stall low. Output channel: one result word
// (body byte, first/last marks, empty flag, frame length, protocol error)
// taken at an edge with o_res_valid high and i_res_stall low.
// Each record opens with five header bytes; the first three are dropped
// unchecked, the last two give the big-endian body length. Header bytes
// give no word. Body bytes come out one for one; an empty record gives one
// word with empty_frame set. A length above max_body_length gives one
// word with protocol_error set, and every later byte is dropped until reset.
// Results are registered in the result register (skid stage if stalled).
// Throughput: one byte per cycle while o_rx_stall is low, set by the
// combinational header/counter step between input and result register.
// Stall: a result register plus a one-word skid stage hold results while
// the receiver stalls; o_rx_stall rises only once both are full.
// Reset (i_rst_n low, synchronous) empties both stages, clears the header
// position and the error flag, and sets max_body_length to 16384.
// max_body_length is written over the APB port at byte address 0; write it
// only while the block is idle.
module record_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                            pready,
    input  logic                            i_rx_valid,
    output logic                            o_rx_stall,
    input  logic [rd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output logic [rd_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                            o_first_of_frame,
    output logic                            o_last_of_frame,
    output logic                            o_empty_frame,
    output logic [rd_pkg::LEN_W-1:0]        o_frame_length,
    output logic                            o_protocol_error
);
    import rd_pkg::*;

    logic [LEN_W-1:0] w_max_len;
    logic             w_take;
    logic             w_push;
    logic             w_full;
    t_result          w_res;
    t_result          w_out;

    rd_cfg u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_max_body_length (w_max_len)
    );

    // Accept a byte whenever the skid stage has room.
    assign o_rx_stall = w_full;
    assign w_take     = i_rx_valid & ~w_full;

    rd_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (w_take),
        .i_rx_byte         (i_rx_byte),
        .i_max_body_length (w_max_len),
        .o_res_push        (w_push),
        .o_res             (w_res)
    );

    rd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_res   (w_out)
    );

    assign o_payload_byte   = w_out.payload_byte;
    assign o_first_of_frame = w_out.first_of_frame;
    assign o_last_of_frame  = w_out.last_of_frame;
    assign o_empty_frame    = w_out.empty_frame;
    assign o_frame_length   = w_out.frame_length;
    assign o_protocol_error = w_out.protocol_error;

`ifndef SYNTH
    a_stall_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("input stalled with no result pending");
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_protocol_error) |->
            (!o_first_of_frame && !o_last_of_frame && !o_empty_frame))
        else $error("error word carries frame marks");
    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_empty_frame) |->
            (o_first_of_frame && o_last_of_frame && o_frame_length == '0))
        else $error("empty frame word malformed");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for record_deframer: wire bytes in, body words out.
// Depends on rd_pkg for widths, header positions and the result word type.
module testbench;
    import rd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    // Cycles the receiver holds off in one go; far longer than the two-stage
    // output path, so the block must stall its input.
    localparam int LONG_HOLD = 80;
    localparam int PHASE_ITEMS = 560;
    localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_BODY_LENGTH, 2'b00};

    // Scoreboard: carries its own copy of the parser state and the limit,
    // predicts the word, if any, each accepted byte gives and queues it in order.
    class deframe_scoreboard;
        logic [LEN_W-1:0]  max_len;
        logic [IDX_W-1:0]  hdr_pos;
        logic [BYTE_W-1:0] len_hi;
        logic [LEN_W-1:0]  body_len;
        logic [LEN_W-1:0]  remaining;
        bit                broken;
        t_result           expected_words[$];
        int                mismatches;

        function void clear();
            max_len   = MAX_BODY_RESET;
            hdr_pos   = HDR_FIRST_POS;
            len_hi    = '0;
            body_len  = '0;
            remaining = '0;
            broken    = 1'b0;
            expected_words.delete();
            mismatches = 0;
        endfunction

        function void set_max(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        // Advance the parser by one accepted wire byte.
        function void note_byte(logic [BYTE_W-1:0] b);
            t_result          w;
            logic [LEN_W-1:0] len;
            if (broken)
                return;
            w = '0;
            if (hdr_pos < HDR_LEN_HIGH_POS) begin
                hdr_pos = hdr_pos + 3'd1;
            end else if (hdr_pos == HDR_LEN_HIGH_POS) begin
                len_hi  = b;
                hdr_pos = HDR_LEN_LOW_POS;
            end else if (hdr_pos == HDR_LEN_LOW_POS) begin
                len      = {len_hi, b};
                body_len = len;
                if (len > max_len) begin
                    // oversized: one error word, then the stream is dead
                    broken           = 1'b1;
                    hdr_pos          = HDR_FIRST_POS;
                    remaining        = '0;
                    w.frame_length   = len;
                    w.protocol_error = 1'b1;
                    expected_words.push_back(w);
                end else if (len == '0) begin
                    hdr_pos          = HDR_FIRST_POS;
                    remaining        = '0;
                    w.first_of_frame = 1'b1;
                    w.last_of_frame  = 1'b1;
                    w.empty_frame    = 1'b1;
                    expected_words.push_back(w);
                end else begin
                    remaining = len;
                    hdr_pos   = BODY_PHASE;
                end
            end else begin
                // body phase, also any position past it
                w.payload_byte   = b;
                w.first_of_frame = (remaining == body_len);
                w.last_of_frame  = (remaining <= 16'd1);
                if (remaining > '0)
                    remaining = remaining - 16'd1;
                if (remaining == '0)
                    hdr_pos = HDR_FIRST_POS;
                w.frame_length = body_len;
                expected_words.push_back(w);
            end
        endfunction

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word %h with none expected", got));
                return;
            end
            want = expected_words.pop_front();
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("first_of_frame", got.first_of_frame, want.first_of_frame);
            compare_field("last_of_frame", got.last_of_frame, want.last_of_frame);
            compare_field("empty_frame", got.empty_frame, want.empty_frame);
            compare_field("frame_length", got.frame_length, want.frame_length);
            compare_field("protocol_error", got.protocol_error, want.protocol_error);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_rx_valid = 1'b0;
    logic                  o_rx_stall;
    logic [BYTE_W-1:0]     i_rx_byte = '0;
    logic                  o_res_valid;
    logic                  i_res_stall = 1'b0;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic                  o_first_of_frame;
    logic                  o_last_of_frame;
    logic                  o_empty_frame;
    logic [LEN_W-1:0]      o_frame_length;
    logic                  o_protocol_error;

    deframe_scoreboard sb = new;

    int          tx_idle_pct = 31;
    int          rx_idle_pct = 81;
    int          items_sent = 0;
    int          cycle_count = 0;
    // Long hold-offs: the stimulus raises requests, the receiver serves them.
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int unsigned max_setting = MAX_BODY_RESET;

    record_deframer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_payload_byte   (o_payload_byte),
        .o_first_of_frame (o_first_of_frame),
        .o_last_of_frame  (o_last_of_frame),
        .o_empty_frame    (o_empty_frame),
        .o_frame_length   (o_frame_length),
        .o_protocol_error (o_protocol_error)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: serve a pending long hold first, else stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_res_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD - 1;
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Monitor: sample both handshakes with pre-edge values. A word taken at
    // this edge belongs to a byte taken at an earlier edge, so the order of
    // the two calls does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_stall === 1'b0)
                sb.note_byte(i_rx_byte);
            if (o_res_valid === 1'b1 && !i_res_stall)
                sb.check_word(t_result'({o_payload_byte, o_first_of_frame,
                                         o_last_of_frame, o_empty_frame,
                                         o_frame_length, o_protocol_error}));
        end
    end

    // Offer one wire byte, idling first at random; return at the edge that
    // takes it. Valid stays high so back-to-back bytes need no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall !== 1'b0)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Send a whole record: three unchecked header bytes, big-endian length,
    // then the body.
    task automatic send_record(input int unsigned len);
        logic [LEN_W-1:0] l;
        l = len[LEN_W-1:0];
        repeat (3) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(l[15:8]);
        send_byte(l[7:0]);
        repeat (len) send_byte(BYTE_W'($urandom_range(255)));
    endtask

    // Mostly short bodies, some empty, a few long ones or exactly the limit.
    function automatic int unsigned pick_length(int unsigned lim);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 80)
            return $urandom_range((lim < 12) ? lim : 12, 1);
        if (r < 95)
            return $urandom_range((lim < 80) ? lim : 80, 1);
        return (lim <= 600) ? lim : $urandom_range(600, 256);
    endfunction

    task automatic send_random_records(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            send_record(pick_length(max_setting));
    endtask

    // Drop valid and hold off until every expected word is back, plus the
    // block's latency for bytes that give no word.
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr,
                            output logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_max_readback(input logic [LEN_W-1:0] want);
        logic [CFG_DATA_W-1:0] rd;
        apb_read(MAX_LEN_ADDR, rd);
        if (rd[LEN_W-1:0] !== want)
            sb.report_mismatch($sformatf("max_body_length read %0h expected %0h",
                                         rd[LEN_W-1:0], want));
    endtask

    // Change the limit only with the block idle, then read it back.
    task automatic set_max_length(input logic [LEN_W-1:0] v);
        wait_drained();
        apb_write(MAX_LEN_ADDR, CFG_DATA_W'(v));
        sb.set_max(v);
        max_setting = v;
        check_max_readback(v);
    endtask

    initial begin
        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: limit at its reset value.
        check_max_readback(MAX_BODY_RESET);
        // empty record
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h00);
        // one-byte record, the three unchecked header bytes high
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hFF);
        // three-byte record with extreme body bytes
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h03);
        send_byte(8'h00); send_byte(8'hA5); send_byte(8'hFF);
        // smallest limit; a body of exactly the limit passes
        set_max_length(16'd1);
        send_byte(8'h17); send_byte(8'h03); send_byte(8'h03);
        send_byte(8'h00); send_byte(8'h01);
        send_byte(8'h00);

        // Phase one: sender idles lightly, receiver heavily.
        send_random_records(100);
        set_max_length(16'hFFFF);
        send_random_records(PHASE_ITEMS - 100);
        // Lower the limit below a record already in its body; the record
        // must finish under the old limit.
        send_record(0);
        repeat (3) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'h00); send_byte(8'd40);
        repeat (10) send_byte(BYTE_W'($urandom_range(255)));
        set_max_length(16'd9);

        // Phase two: sender idles heavily, receiver lightly.
        tx_idle_pct = 81;
        rx_idle_pct = 31;
        repeat (30) send_byte(BYTE_W'($urandom_range(255)));
        send_random_records(PHASE_ITEMS);
        // Change the limit between the two length bytes of a header.
        repeat (3) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'h00);
        set_max_length(LEN_W'($urandom_range(600, 300)));

        // Phase three: no idling, and one long receiver hold-off while the
        // sender keeps offering, so the output path fills and stalls input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests = hold_requests + 1;
        send_byte(8'd9);
        repeat (9) send_byte(BYTE_W'($urandom_range(255)));
        send_random_records(PHASE_ITEMS);

        // Oversized length at the top of the range: one error word, then
        // every later byte is dropped.
        set_max_length(16'hFFFE);
        repeat (3) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(8'hFF); send_byte(8'hFF);
        send_record(2);
        repeat (20) send_byte(BYTE_W'($urandom_range(255)));

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- record_deframer.f -----
rtl/rd_pkg.sv
rtl/rd_cfg.sv
rtl/rd_parse.sv
rtl/rd_outbuf.sv
rtl/record_deframer.sv
test/testbench.sv
